FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge with an
// active-low reset that disables the check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// An antecedent that implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// An antecedent that implies a consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: rtl/ast_pkg.sv
// ----------------------------------------------------------------------------
// Assembly source tokenizer package
// Token kinds, character codes, default widths and character classes.
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam int unsigned AST_OFFSET_BITS   = 24;
  localparam int unsigned AST_POSITION_BITS = 16;
  localparam int unsigned LEN_BITS          = 16;
  localparam int unsigned VALUE_BITS        = 64;

  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  typedef enum logic [2:0] {
    KIND_IDENT    = 3'd0,
    KIND_NUMBER   = 3'd1,
    KIND_COMMA    = 3'd2,
    KIND_LBRACKET = 3'd3,
    KIND_RBRACKET = 3'd4,
    KIND_NEWLINE  = 3'd5,
    KIND_END      = 3'd6,
    KIND_BAD      = 3'd7
  } token_kind_e;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_LBR   = 8'h5B;
  localparam logic [7:0] CHAR_RBR   = 8'h5D;
  localparam logic [7:0] CHAR_US    = 8'h5F;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CHAR_LO_A) && (c <= CHAR_LO_Z)) ||
           ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z)) || (c == CHAR_US);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

FILE: rtl/assembly_source_tokenizer_core.sv
// A token is written into the result queue when the byte that completes it is taken.
// One byte per cycle while ready is high; a byte may complete up to two tokens.
// Ready drops only when the four-entry result queue has fewer than two free slots.
// Reset empties the queue and sets offset 0, line 1, column 1, between tokens.
// ----------------------------------------------------------------------------
// Assembly source tokenizer core
// Streaming lexer: one source byte per item, tokens queued for the output.
// ----------------------------------------------------------------------------
module assembly_source_tokenizer_core import ast_pkg::*; #(
  parameter int unsigned OFFSET_BITS   = AST_OFFSET_BITS,
  parameter int unsigned POSITION_BITS = AST_POSITION_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     func_i,
  input  logic [7:0]               char_code_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               token_kind_o,
  output logic [POSITION_BITS-1:0] start_line_o,
  output logic [POSITION_BITS-1:0] start_column_o,
  output logic [OFFSET_BITS-1:0]   start_offset_o,
  output logic [LEN_BITS-1:0]      token_length_o,
  output logic [VALUE_BITS-1:0]    number_value_o,
  output logic                     last_of_run_o
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR   = $clog2(QDEPTH);
  localparam int unsigned QCNT   = $clog2(QDEPTH + 1);
  localparam int unsigned PROD_BITS = VALUE_BITS + 4;

  localparam logic [OFFSET_BITS-1:0]   OFFSET_MAX = '1;
  localparam logic [POSITION_BITS-1:0] POS_MAX    = '1;
  localparam logic [POSITION_BITS-1:0] POS_ONE    = POSITION_BITS'(1);
  localparam logic [QCNT-1:0]          QCNT_LIMIT = QCNT'(QDEPTH - 2);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_COMMENT,
    MODE_DONE
  } mode_e;

  typedef struct packed {
    token_kind_e              kind;
    logic [POSITION_BITS-1:0] line;
    logic [POSITION_BITS-1:0] column;
    logic [OFFSET_BITS-1:0]   offset;
    logic [LEN_BITS-1:0]      length;
    logic [VALUE_BITS-1:0]    value;
    logic                     last;
  } tok_t;

  mode_e                    mode_q, mode_d;
  logic [OFFSET_BITS-1:0]   cur_off_q, cur_off_d, tok_off_q, tok_off_d;
  logic [POSITION_BITS-1:0] cur_line_q, cur_line_d, tok_line_q, tok_line_d;
  logic [POSITION_BITS-1:0] cur_col_q, cur_col_d, tok_col_q, tok_col_d;
  logic [VALUE_BITS-1:0]    acc_q, acc_d;
  logic                     octal_q, octal_d, stop_q, stop_d, sat_q, sat_d;
  logic [LEN_BITS-1:0]      len_q, len_d;

  tok_t                     queue_q [QDEPTH];
  logic [QPTR-1:0]          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT-1:0]          count_q, count_d;

  logic                     in_fire, out_fire, at_end, do_consume;
  logic                     flush_v, tail_v;
  token_kind_e              flush_kind, tail_kind;
  tok_t                     flush_tok, tail_tok, res_a, res_b;
  logic [QCNT-1:0]          n_res;
  logic [3:0]               digit;
  logic [PROD_BITS-1:0]     prod, sum;
  logic [OFFSET_BITS-1:0]   off_inc;
  logic [POSITION_BITS-1:0] line_inc, col_inc;
  logic [LEN_BITS-1:0]      len_inc;

  assign in_ready_o = (count_q <= QCNT_LIMIT);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_fire   = out_valid_o && out_ready_i;
  assign at_end     = func_i || (char_code_i == CHAR_NUL);

  assign off_inc  = (cur_off_q == OFFSET_MAX) ? cur_off_q : cur_off_q + OFFSET_BITS'(1);
  assign line_inc = (cur_line_q == POS_MAX) ? cur_line_q : cur_line_q + POS_ONE;
  assign col_inc  = (cur_col_q == POS_MAX) ? cur_col_q : cur_col_q + POS_ONE;
  assign len_inc  = (len_q == LEN_MAX) ? len_q : len_q + LEN_BITS'(1);

  // Constant-multiply accumulate; any carry into the top bits means overflow.
  assign digit = char_code_i[3:0];
  assign prod  = octal_q ? {1'b0, acc_q, 3'b000}
                         : ({1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0});
  assign sum   = prod + {{(PROD_BITS-4){1'b0}}, digit};

  always_comb begin
    mode_d     = mode_q;
    cur_off_d  = cur_off_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    tok_off_d  = tok_off_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    acc_d      = acc_q;
    octal_d    = octal_q;
    stop_d     = stop_q;
    sat_d      = sat_q;
    len_d      = len_q;
    do_consume = 1'b0;
    flush_v    = 1'b0;
    flush_kind = KIND_IDENT;
    tail_v     = 1'b0;
    tail_kind  = KIND_END;

    if (in_fire && (mode_q != MODE_DONE)) begin
      logic handled;
      handled = 1'b0;
      case (mode_q)
        MODE_IDENT: begin
          if (!at_end && (is_letter(char_code_i) || is_digit(char_code_i))) begin
            len_d      = len_inc;
            do_consume = 1'b1;
            handled    = 1'b1;
          end else begin
            flush_v    = 1'b1;
            flush_kind = KIND_IDENT;
            mode_d     = MODE_IDLE;
          end
        end
        MODE_NUMBER: begin
          if (!at_end && is_digit(char_code_i)) begin
            if (!sat_q && !stop_q) begin
              if (octal_q && digit[3]) begin
                stop_d = 1'b1;
              end else if (sum[PROD_BITS-1:VALUE_BITS] != '0) begin
                acc_d = '1;
                sat_d = 1'b1;
              end else begin
                acc_d = sum[VALUE_BITS-1:0];
              end
            end
            len_d      = len_inc;
            do_consume = 1'b1;
            handled    = 1'b1;
          end else begin
            flush_v    = 1'b1;
            flush_kind = KIND_NUMBER;
            mode_d     = MODE_IDLE;
          end
        end
        MODE_COMMENT: begin
          if (!at_end && (char_code_i != CHAR_NL)) begin
            do_consume = 1'b1;
            handled    = 1'b1;
          end else begin
            mode_d = MODE_IDLE;
          end
        end
        default: begin
        end
      endcase

      if (!handled) begin
        if (at_end) begin
          tok_off_d  = cur_off_q;
          tok_line_d = cur_line_q;
          tok_col_d  = cur_col_q;
          tail_v     = 1'b1;
          tail_kind  = KIND_END;
          mode_d     = MODE_DONE;
        end else if ((char_code_i == CHAR_SPACE) || (char_code_i == CHAR_TAB) ||
                     (char_code_i == CHAR_CR)) begin
          do_consume = 1'b1;
        end else if (char_code_i == CHAR_SEMI) begin
          mode_d     = MODE_COMMENT;
          do_consume = 1'b1;
        end else begin
          tok_off_d  = cur_off_q;
          tok_line_d = cur_line_q;
          tok_col_d  = cur_col_q;
          len_d      = LEN_BITS'(1);
          do_consume = 1'b1;
          if (is_letter(char_code_i)) begin
            mode_d = MODE_IDENT;
          end else if (is_digit(char_code_i)) begin
            mode_d  = MODE_NUMBER;
            acc_d   = {{(VALUE_BITS-4){1'b0}}, digit};
            octal_d = (char_code_i == CHAR_ZERO);
            stop_d  = 1'b0;
            sat_d   = 1'b0;
          end else begin
            tail_v = 1'b1;
            if (char_code_i == CHAR_NL) begin
              tail_kind = KIND_NEWLINE;
            end else if (char_code_i == CHAR_COMMA) begin
              tail_kind = KIND_COMMA;
            end else if (char_code_i == CHAR_LBR) begin
              tail_kind = KIND_LBRACKET;
            end else if (char_code_i == CHAR_RBR) begin
              tail_kind = KIND_RBRACKET;
            end else begin
              tail_kind = KIND_BAD;
            end
          end
        end
      end

      if (do_consume) begin
        cur_off_d = off_inc;
        if (char_code_i == CHAR_NL) begin
          cur_line_d = line_inc;
          cur_col_d  = POS_ONE;
        end else begin
          cur_col_d = col_inc;
        end
      end
    end
  end

  always_comb begin
    flush_tok.kind   = flush_kind;
    flush_tok.line   = tok_line_q;
    flush_tok.column = tok_col_q;
    flush_tok.offset = tok_off_q;
    flush_tok.length = len_q;
    flush_tok.value  = (flush_kind == KIND_NUMBER) ? acc_q : '0;
    flush_tok.last   = !tail_v;

    tail_tok.kind   = tail_kind;
    tail_tok.line   = cur_line_q;
    tail_tok.column = cur_col_q;
    tail_tok.offset = cur_off_q;
    tail_tok.length = (tail_kind == KIND_END) ? '0 : LEN_BITS'(1);
    tail_tok.value  = '0;
    tail_tok.last   = 1'b1;

    res_a = flush_v ? flush_tok : tail_tok;
    res_b = tail_tok;
    n_res = QCNT'(flush_v) + QCNT'(tail_v);

    wr_ptr_d = wr_ptr_q + QPTR'(n_res);
    rd_ptr_d = rd_ptr_q + QPTR'(out_fire);
    count_d  = count_q + n_res - QCNT'(out_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      cur_off_q  <= '0;
      cur_line_q <= POS_ONE;
      cur_col_q  <= POS_ONE;
      tok_off_q  <= '0;
      tok_line_q <= POS_ONE;
      tok_col_q  <= POS_ONE;
      acc_q      <= '0;
      octal_q    <= 1'b0;
      stop_q     <= 1'b0;
      sat_q      <= 1'b0;
      len_q      <= '0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
    end else begin
      mode_q     <= mode_d;
      cur_off_q  <= cur_off_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      tok_off_q  <= tok_off_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      acc_q      <= acc_d;
      octal_q    <= octal_d;
      stop_q     <= stop_d;
      sat_q      <= sat_d;
      len_q      <= len_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_res != '0) begin
      queue_q[wr_ptr_q] <= res_a;
    end
    if (n_res == QCNT'(2)) begin
      queue_q[wr_ptr_q + QPTR'(1)] <= res_b;
    end
  end

  assign token_kind_o   = queue_q[rd_ptr_q].kind;
  assign start_line_o   = queue_q[rd_ptr_q].line;
  assign start_column_o = queue_q[rd_ptr_q].column;
  assign start_offset_o = queue_q[rd_ptr_q].offset;
  assign token_length_o = queue_q[rd_ptr_q].length;
  assign number_value_o = queue_q[rd_ptr_q].value;
  assign last_of_run_o  = queue_q[rd_ptr_q].last;

endmodule

FILE: rtl/ast_checker.sv
// ----------------------------------------------------------------------------
// Assembly source tokenizer checker
// Port-level checks on the byte and token streams, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ast_checker import ast_pkg::*; #(
  parameter int unsigned OFFSET_BITS   = AST_OFFSET_BITS,
  parameter int unsigned POSITION_BITS = AST_POSITION_BITS
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     func_i,
  input logic [7:0]               char_code_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [2:0]               token_kind_o,
  input logic [POSITION_BITS-1:0] start_line_o,
  input logic [POSITION_BITS-1:0] start_column_o,
  input logic [OFFSET_BITS-1:0]   start_offset_o,
  input logic [LEN_BITS-1:0]      token_length_o,
  input logic [VALUE_BITS-1:0]    number_value_o,
  input logic                     last_of_run_o
);

  localparam int unsigned SHOWN_BITS =
    4 + 2 * POSITION_BITS + OFFSET_BITS + LEN_BITS + VALUE_BITS;

  logic                  end_seen_q;
  logic                  is_end, is_single, stalled, in_stalled, end_ok, single_ok;
  logic [8:0]            in_item;
  logic [SHOWN_BITS-1:0] shown;

  assign is_end    = (token_kind_o == KIND_END);
  assign is_single = (token_kind_o == KIND_COMMA) || (token_kind_o == KIND_LBRACKET) ||
                     (token_kind_o == KIND_RBRACKET) || (token_kind_o == KIND_NEWLINE) ||
                     (token_kind_o == KIND_BAD);
  assign stalled    = out_valid_o && !out_ready_i;
  assign in_stalled = in_valid_i && !in_ready_o;
  assign in_item    = {func_i, char_code_i};
  assign shown      = {token_kind_o, start_line_o, start_column_o, start_offset_o,
                       token_length_o, number_value_o, last_of_run_o};
  assign end_ok     = last_of_run_o && (token_length_o == '0) && (number_value_o == '0);
  assign single_ok  = last_of_run_o && (token_length_o == LEN_BITS'(1)) &&
                      (number_value_o == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_seen_q <= 1'b0;
    end else if (out_valid_o && out_ready_i && is_end) begin
      end_seen_q <= 1'b1;
    end
  end

  `ASSERT_NEXT(out_hold_a, clk_i, rst_ni, stalled, out_valid_o && $stable(shown))
  `ASSERT_NEXT(in_hold_a, clk_i, rst_ni, in_stalled, in_valid_i && $stable(in_item))
  `ASSERT_IMPLIES(end_shape_a, clk_i, rst_ni, out_valid_o && is_end, end_ok)
  `ASSERT_IMPLIES(single_shape_a, clk_i, rst_ni, out_valid_o && is_single, single_ok)
  `ASSERT_ALWAYS(quiet_after_end_a, clk_i, rst_ni, !(end_seen_q && out_valid_o))

endmodule

bind assembly_source_tokenizer_core ast_checker #(
  .OFFSET_BITS  (OFFSET_BITS),
  .POSITION_BITS(POSITION_BITS)
) u_ast_checker (.*);
